[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define SMC_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/smc_pkg.sv]
// Shared types, constants and a function of the scanline marker classifier.
// No dependencies.
package smc_pkg;

    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = 10;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [15:0] ROW_GAIN_RST   = 16'd16384;
    localparam logic [15:0] FRAME_GAIN_RST = 16'd64;
    localparam logic [15:0] START_THR_RST  = 16'd8192;

    localparam logic [1:0] CFG_ROW_GAIN   = 2'd0;
    localparam logic [1:0] CFG_FRAME_GAIN = 2'd1;
    localparam logic [1:0] CFG_START_THR  = 2'd2;

    typedef enum logic [2:0] {
        LBL_LBLACK  = 3'd0,
        LBL_LWHITE  = 3'd1,
        LBL_CBLACK  = 3'd2,
        LBL_RWHITE  = 3'd3,
        LBL_RBLACK  = 3'd4,
        LBL_DARK    = 3'd5,
        LBL_BRIGHT  = 3'd6,
        LBL_NEUTRAL = 3'd7
    } t_label;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_first;
        logic       frame_last;
    } t_in;

    typedef struct packed {
        t_label      label;
        logic [23:0] pixel_rgb;
        logic        marker_end;
        logic [9:0]  marker_left_col;
        logic [9:0]  marker_right_col;
        logic [9:0]  black_total;
        logic [9:0]  white_total;
    } t_out;

    // classified pixel handed from front to back
    typedef struct packed {
        logic row_first;
        logic black;
        logic white;
    } t_cls;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg;

    function automatic logic [23:0] label_rgb(input t_label lbl);
        logic [23:0] rgb;
        case (lbl)
            LBL_LBLACK:  rgb = 24'hFF0000;
            LBL_LWHITE:  rgb = 24'hFF8000;
            LBL_CBLACK:  rgb = 24'hFFFF00;
            LBL_RWHITE:  rgb = 24'h00FF00;
            LBL_RBLACK:  rgb = 24'h0080FF;
            LBL_DARK:    rgb = 24'h000000;
            LBL_BRIGHT:  rgb = 24'hFFFFFF;
            default:     rgb = 24'h404040;
        endcase
        return rgb;
    endfunction

endpackage

[rtl/smc_queue.sv]
// Two-entry queue of classified pixels between front and back.
// Depends on smc_pkg.
module smc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smc_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output smc_pkg::t_cls o_data,
    output logic          o_empty
);
    import smc_pkg::*;

    t_cls       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/smc_front.sv]
// Front end: configuration registers, row and frame running averages,
// dark/bright classification of each accepted pixel. Depends on smc_pkg.
module smc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  smc_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  smc_pkg::t_in  i_in,
    output smc_pkg::t_cls o_cls
);
    import smc_pkg::*;

    logic [15:0] r_row_gain;
    logic [15:0] r_frame_gain;
    logic [15:0] r_row_avg;
    logic [15:0] r_frame_avg;
    logic [15:0] r_thresh;

    logic [15:0]        row_base;
    logic signed [16:0] p256;
    logic signed [16:0] rd;
    logic signed [16:0] fd;
    logic [16:0]        mag;
    logic               over;
    logic [15:0]        n_row_avg;
    logic [15:0]        n_frame_avg;

    // avg + floor((gain*d + 32768) / 65536), clamped to 16 bits
    function automatic logic [15:0] avg_update(input logic [15:0] avg,
                                               input logic [15:0] gain,
                                               input logic signed [16:0] d);
        logic signed [33:0] p;
        logic signed [17:0] q;
        logic signed [18:0] r;
        logic [15:0]        res;
        p = $signed({18'd0, gain}) * $signed({{17{d[16]}}, d});
        p = p + 34'sd32768;
        q = 18'(p >>> 16);
        r = $signed({3'b000, avg}) + $signed({q[17], q});
        if (r < 19'sd0) begin
            res = 16'd0;
        end else if (r > 19'sd65535) begin
            res = 16'hFFFF;
        end else begin
            res = r[15:0];
        end
        return res;
    endfunction

    assign row_base    = i_in.row_first ? 16'd0 : r_row_avg;
    assign p256        = $signed({1'b0, i_in.pixel, 8'd0});
    assign rd          = p256 - $signed({1'b0, row_base});
    assign fd          = p256 - $signed({1'b0, r_frame_avg});
    assign mag         = rd[16] ? 17'(-rd) : 17'(rd);
    assign over        = (mag > {1'b0, r_thresh});
    assign n_row_avg   = avg_update(row_base, r_row_gain, rd);
    assign n_frame_avg = avg_update(r_frame_avg, r_frame_gain, fd);

    assign o_cls.row_first = i_in.row_first;
    assign o_cls.black     = over && rd[16];
    assign o_cls.white     = over && !rd[16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_gain   <= ROW_GAIN_RST;
            r_frame_gain <= FRAME_GAIN_RST;
            r_row_avg    <= 16'd0;
            r_frame_avg  <= START_THR_RST;
            r_thresh     <= START_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg.index)
                CFG_ROW_GAIN: begin
                    r_row_gain <= i_cfg.data;
                end
                CFG_FRAME_GAIN: begin
                    r_frame_gain <= i_cfg.data;
                end
                CFG_START_THR: begin
                    r_frame_avg <= i_cfg.data;
                    r_thresh    <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            r_row_avg   <= n_row_avg;
            r_frame_avg <= n_frame_avg;
            if (i_in.frame_last) begin
                r_thresh <= n_frame_avg;
            end
        end
    end

endmodule

[rtl/smc_back.sv]
// Back end: five-phase marker pattern machine, phase counters, column
// tracking, labeling and a two-entry result queue. Depends on smc_pkg.
module smc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cls_empty,
    input  smc_pkg::t_cls i_cls,
    output logic          o_cls_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output smc_pkg::t_out o_out
);
    import smc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LB,
        PH_LW,
        PH_CB,
        PH_RW,
        PH_RB
    } t_phase;

    t_phase           r_phase;
    logic [COL_W-1:0] r_column;
    logic [COL_W-1:0] r_start;
    logic [CNT_W-1:0] r_cnt [5];

    t_out             r_out [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    t_phase           n_phase;
    logic [COL_W-1:0] n_column;
    logic [COL_W-1:0] n_start;
    logic [CNT_W-1:0] n_cnt [5];
    t_out             res;

    logic [COL_W-1:0] col;
    logic [CNT_W+1:0] bsum;
    logic [CNT_W+1:0] wsum;
    logic             blk;
    logic             wht;
    logic             done;
    logic             out_pop;

    assign out_pop   = i_pop && (r_count != 2'd0);
    assign o_cls_pop = !i_cls_empty && (r_count != 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_out     = r_out[r_rd_ptr];

    always_comb begin
        blk = i_cls.black;
        wht = i_cls.white;
        done = 1'b0;
        bsum = '0;
        wsum = '0;
        if (i_cls.row_first) begin
            n_phase = PH_IDLE;
            col     = '0;
            n_start = '0;
            for (int i = 0; i < 5; i++) begin
                n_cnt[i] = '0;
            end
        end else begin
            n_phase = r_phase;
            col     = r_column;
            n_start = r_start;
            for (int i = 0; i < 5; i++) begin
                n_cnt[i] = r_cnt[i];
            end
        end

        if (blk && n_phase == PH_IDLE) begin
            n_phase = PH_LB;
            n_start = col;
        end
        if (!wht && n_phase == PH_LW) n_phase = PH_CB;
        if (!wht && n_phase == PH_RW) n_phase = PH_RB;
        if (!blk && n_phase == PH_LB) n_phase = PH_LW;
        if (!blk && n_phase == PH_CB) n_phase = PH_RW;

        if (!wht && n_phase == PH_LB) begin
            if (n_cnt[0] != CNT_MAX) n_cnt[0] = n_cnt[0] + CNT_W'(1);
        end else if (!wht && n_phase == PH_RB) begin
            if (n_cnt[4] != CNT_MAX) n_cnt[4] = n_cnt[4] + CNT_W'(1);
        end else if (!wht && n_phase == PH_CB) begin
            if (n_cnt[2] != CNT_MAX) n_cnt[2] = n_cnt[2] + CNT_W'(1);
        end else if (!blk && n_phase == PH_LW) begin
            if (n_cnt[1] != CNT_MAX) n_cnt[1] = n_cnt[1] + CNT_W'(1);
        end else if (!blk && n_phase == PH_RW) begin
            if (n_cnt[3] != CNT_MAX) n_cnt[3] = n_cnt[3] + CNT_W'(1);
        end

        if (!blk && n_phase == PH_RB) begin
            done    = 1'b1;
            n_phase = PH_IDLE;
            bsum    = {2'b00, n_cnt[0]} + {2'b00, n_cnt[2]} + {2'b00, n_cnt[4]};
            wsum    = {2'b00, n_cnt[1]} + {2'b00, n_cnt[3]};
            if (bsum > {2'b00, CNT_MAX}) bsum = {2'b00, CNT_MAX};
            if (wsum > {2'b00, CNT_MAX}) wsum = {2'b00, CNT_MAX};
            for (int i = 0; i < 5; i++) begin
                n_cnt[i] = '0;
            end
        end

        case (n_phase)
            PH_LB:   res.label = LBL_LBLACK;
            PH_LW:   res.label = LBL_LWHITE;
            PH_CB:   res.label = LBL_CBLACK;
            PH_RW:   res.label = LBL_RWHITE;
            PH_RB:   res.label = LBL_RBLACK;
            default: res.label = blk ? LBL_DARK : (wht ? LBL_BRIGHT : LBL_NEUTRAL);
        endcase
        res.pixel_rgb        = label_rgb(res.label);
        res.marker_end       = done;
        res.marker_left_col  = done ? 10'(n_start) : 10'd0;
        res.marker_right_col = done ? 10'(col) : 10'd0;
        res.black_total      = bsum[9:0];
        res.white_total      = wsum[9:0];

        n_column = (col < COL_W'(MAX_COLS - 1)) ? col + COL_W'(1) : col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_column <= '0;
            r_start  <= '0;
            for (int i = 0; i < 5; i++) begin
                r_cnt[i] <= '0;
            end
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (o_cls_pop) begin
                r_phase  <= n_phase;
                r_column <= n_column;
                r_start  <= n_start;
                for (int i = 0; i < 5; i++) begin
                    r_cnt[i] <= n_cnt[i];
                end
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (o_cls_pop && !out_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!o_cls_pop && out_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_pop) begin
            r_out[r_wr_ptr] <= res;
        end
    end

endmodule

[rtl/scanline_marker_classifier_core.sv]
// Top level of the scanline marker classifier: front, queue and back.
// Depends on smc_pkg, smc_front, smc_queue, smc_back.
//
// Sustains one pixel per clock unless a full queue stalls it: the row and
// frame averages each close a single multiply-add loop per pixel in the
// front, and the phase machine in the back closes its own loop. An accepted
// pixel is registered in the queue, and the back registers its result in
// the result queue, from which it can be popped; the two-entry queue and
// the two-entry result queue let either side stall on its own.
// Configuration writes are taken in any cycle (cfg ready is always high)
// and must be issued only while the block is idle.
module scanline_marker_classifier_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  smc_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output smc_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import smc_pkg::*;

    t_cls front_cls;
    t_cls back_cls;
    t_cfg cfg;
    logic accept;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;
    assign full        = q_full;
    assign accept      = push && !q_full;

    smc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_valid),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_in     (i_in),
        .o_cls    (front_cls)
    );

    smc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (back_cls),
        .o_empty (q_empty)
    );

    smc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_empty (q_empty),
        .i_cls       (back_cls),
        .o_cls_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

[rtl/smc_checker.sv]
// Port-level checks of the scanline marker classifier, bound to the top.
// Depends on smc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input smc_pkg::t_out o_out
);
    import smc_pkg::*;

    `SMC_ASSERT_RST(a_reset_clears, i_clk, (!i_rst_n |=> (empty && !full)), "queues not empty after reset")

    `SMC_ASSERT(a_end_label, i_clk, i_rst_n, ((!empty && o_out.marker_end) |-> (o_out.label == LBL_BRIGHT || o_out.label == LBL_NEUTRAL)), "marker end with pattern label")

    `SMC_ASSERT(a_no_end_zero, i_clk, i_rst_n, ((!empty && !o_out.marker_end) |-> (o_out.marker_left_col == 10'd0 && o_out.marker_right_col == 10'd0 && o_out.black_total == 10'd0 && o_out.white_total == 10'd0)), "marker fields set without marker end")

    `SMC_ASSERT(a_result_held, i_clk, i_rst_n, ((!empty && !pop) |=> (!empty && $stable(o_out))), "waiting result changed")

endmodule

bind scanline_marker_classifier_core smc_checker u_smc_checker (.*);
